// ===== hw/rtl/ltc_pkg.sv =====
// Shared types and codes for the domain tag cache.
`default_nettype none
package ltc_pkg;

	localparam int KEY_W = 64;
	localparam int OCC_W = 7;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic [1:0] {
		OP_FETCH = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_NEG  = 2'd2,
		ST_OFF  = 2'd3
	} status_t;

	localparam logic CFG_CAPACITY  = 1'b0;
	localparam logic CFG_ON_DEMAND = 1'b1;

	localparam occ_t CAPACITY_RST = 7'd2;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic look;       // compare the request key this cycle
		logic shift_hit;  // move the hit entry to the front
		logic shift_miss; // insert at the front, shifting the first count cells
		occ_t occ;        // live entries
		occ_t count;      // cells touched by a miss insertion
		key_t key;        // request key, time step in the upper half
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ltc_cell.sv =====
// One position of the recency chain: key register, tag compare and shift.
`default_nettype none
module ltc_cell #(
	parameter int IDX = 0
) (
	input  wire                clk,
	input  wire                arst_n,
	input  ltc_pkg::cell_ctl_t ctl,
	input  ltc_pkg::key_t      prev_key,
	output ltc_pkg::key_t      key_out,
	input  wire                hit_in,
	output logic               hit_out,
	input  ltc_pkg::key_t      tap_in,
	output ltc_pkg::key_t      tap_out
);

	localparam ltc_pkg::occ_t POS = ltc_pkg::occ_t'(IDX);

	ltc_pkg::key_t key_q;
	logic          match_q;
	logic          live;
	logic          shift;

	assign live    = POS < ctl.occ;
	assign hit_out = hit_in | match_q;
	// cells at or in front of the hit move back by one
	assign shift   = ctl.shift_hit ? (hit_in | match_q)
	                               : (ctl.shift_miss && (POS < ctl.count));
	// least recent live entry sits at occ - 1
	assign tap_out = tap_in | ((POS == ctl.occ - 7'd1) ? key_q : '0);
	assign key_out = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.look) begin
			match_q <= live && (key_q == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= prev_key;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ltc_ctrl.sv =====
// Request sequencer: configuration, occupancy, counters and result register.
`default_nettype none
module ltc_ctrl #(
	parameter int MAX_ENTRIES = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wen,
	input  wire                cfg_index,
	input  wire  [6:0]         cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         operation,
	input  wire  signed [31:0] domain_id,
	input  wire  signed [31:0] time_step,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [1:0]         status,
	output logic               present,
	output logic               evicted_valid,
	output logic signed [31:0] evicted_domain,
	output logic signed [31:0] evicted_time,
	output logic [31:0]        loads_total,
	output logic [31:0]        purges_total,
	output ltc_pkg::cell_ctl_t ctl,
	input  wire                hit_any,
	input  ltc_pkg::key_t      tap_key
);

	localparam ltc_pkg::occ_t MAX_OCC = ltc_pkg::occ_t'(MAX_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_UPD
	} state_t;

	state_t          state_q;
	ltc_pkg::occ_t   capacity_q;
	logic            on_demand_q;
	ltc_pkg::occ_t   occ_q;
	logic [31:0]     loads_q;
	logic [31:0]     purges_q;
	logic [1:0]      op_q;
	logic [31:0]     dom_q;
	logic [31:0]     tim_q;
	ltc_pkg::key_t   tap_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	logic            present_q;
	logic            ev_valid_q;
	ltc_pkg::key_t   ev_key_q;

	ltc_pkg::occ_t   cap_eff;
	logic            out_free;
	logic            upd_fire;
	logic            accept;
	logic            active;
	logic            fetch_hit;
	logic            fetch_miss;
	logic            evict;
	logic [1:0]      status_d;

	assign cap_eff  = (capacity_q > MAX_OCC) ? MAX_OCC : capacity_q;
	assign out_free = !out_valid_q || out_ready;
	assign upd_fire = (state_q == S_UPD) && out_free;
	assign in_ready = (state_q == S_IDLE) || upd_fire;
	assign accept   = in_valid && in_ready;

	assign active     = ((op_q == ltc_pkg::OP_FETCH) || (op_q == ltc_pkg::OP_QUERY))
	                    && on_demand_q && !dom_q[31];
	assign fetch_hit  = active && (op_q == ltc_pkg::OP_FETCH) && hit_any;
	assign fetch_miss = active && (op_q == ltc_pkg::OP_FETCH) && !hit_any;
	assign evict      = fetch_miss && (occ_q >= cap_eff);

	always_comb begin
		status_d = ltc_pkg::ST_DONE;
		if ((op_q == ltc_pkg::OP_FETCH) || (op_q == ltc_pkg::OP_QUERY)) begin
			if (!on_demand_q) begin
				status_d = ltc_pkg::ST_OFF;
			end else if (dom_q[31]) begin
				status_d = ltc_pkg::ST_NEG;
			end else if (fetch_miss) begin
				status_d = ltc_pkg::ST_MISS;
			end
		end
	end

	always_comb begin
		ctl.look       = (state_q == S_LOOK);
		ctl.shift_hit  = upd_fire && fetch_hit;
		ctl.shift_miss = upd_fire && fetch_miss;
		ctl.occ        = occ_q;
		ctl.count      = evict ? occ_q : occ_q + 7'd1;
		ctl.key        = {tim_q, dom_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			capacity_q  <= ltc_pkg::CAPACITY_RST;
			on_demand_q <= 1'b0;
			occ_q       <= '0;
			loads_q     <= '0;
			purges_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == ltc_pkg::CFG_CAPACITY) begin
					capacity_q <= cfg_data;
				end else begin
					on_demand_q <= cfg_data[0];
				end
			end
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_fire) begin
						state_q <= accept ? S_LOOK : S_IDLE;
						if (op_q == ltc_pkg::OP_CLEAR) begin
							occ_q <= '0;
						end else if (fetch_miss && !evict) begin
							occ_q <= occ_q + 7'd1;
						end
						if (fetch_miss) begin
							loads_q <= loads_q + 32'd1;
						end
						if (evict) begin
							purges_q <= purges_q + 32'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			dom_q <= domain_id;
			tim_q <= time_step;
		end
		if (state_q == S_LOOK) begin
			tap_q <= tap_key;
		end
		if (upd_fire) begin
			status_q   <= status_d;
			present_q  <= active && (op_q == ltc_pkg::OP_QUERY) && hit_any;
			ev_valid_q <= evict;
			if (!evict) begin
				ev_key_q <= '0;
			end else if (occ_q == '0) begin
				ev_key_q <= {tim_q, dom_q};
			end else begin
				ev_key_q <= tap_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign present        = present_q;
	assign evicted_valid  = ev_valid_q;
	assign evicted_domain = ev_key_q[31:0];
	assign evicted_time   = ev_key_q[63:32];
	assign loads_total    = loads_q;
	assign purges_total   = purges_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= MAX_OCC)
		else $error("occupancy above store depth");

	a_grow_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && fetch_miss && !evict) |=> (occ_q <= $past(cap_eff)))
		else $error("insertion grew occupancy past capacity");

	a_result_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_UPD))
		else $error("result raised outside the update step");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_valid_q) |-> (status_q == ltc_pkg::ST_MISS))
		else $error("eviction reported without a miss");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lru_domain_tag_cache.sv =====
// Fully associative LRU tag cache keyed by domain id and time step.
//
// Input channel (in_valid/in_ready) takes one request: operation, domain_id,
// time_step. Output channel (out_valid/out_ready) returns one result per
// request. Configuration: cfg_wen writes cfg_data into register cfg_index
// (0 capacity, 1 on_demand) at the clock edge; write only while idle.
// Each request passes through a compare step (S_LOOK), which checks its key
// against every live cell, and an update step (S_UPD), which shifts the
// recency chain and loads the result register; the next request can be
// accepted in the update step of the one before it. The chain length MAX_ENTRIES
// sets the depth of the hit and eviction taps across the cells.
// Reset clears occupancy, the load and purge counters, capacity to 2 and
// on_demand to 0; stored keys are not cleared.
// While the receiver stalls the result is held, the request that follows it
// is compared, and then the block waits before updating the chain.
`default_nettype none
module lru_domain_tag_cache #(
	parameter int MAX_ENTRIES = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wen,
	input  wire                cfg_index,
	input  wire  [6:0]         cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         operation,
	input  wire  signed [31:0] domain_id,
	input  wire  signed [31:0] time_step,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [1:0]         status,
	output logic               present,
	output logic               evicted_valid,
	output logic signed [31:0] evicted_domain,
	output logic signed [31:0] evicted_time,
	output logic [31:0]        loads_total,
	output logic [31:0]        purges_total
);

	ltc_pkg::cell_ctl_t ctl;
	ltc_pkg::key_t      key_c  [MAX_ENTRIES];
	ltc_pkg::key_t      prev_c [MAX_ENTRIES];
	ltc_pkg::key_t      tap_c  [MAX_ENTRIES+1];
	logic               hit_c  [MAX_ENTRIES+1];

	assign tap_c[0]           = '0;
	assign hit_c[MAX_ENTRIES] = 1'b0;

	ltc_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.domain_id      (domain_id),
		.time_step      (time_step),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.present        (present),
		.evicted_valid  (evicted_valid),
		.evicted_domain (evicted_domain),
		.evicted_time   (evicted_time),
		.loads_total    (loads_total),
		.purges_total   (purges_total),
		.ctl            (ctl),
		.hit_any        (hit_c[0]),
		.tap_key        (tap_c[MAX_ENTRIES])
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_c[i] = ctl.key;
		end else begin : g_body
			assign prev_c[i] = key_c[i-1];
		end

		ltc_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev_key (prev_c[i]),
			.key_out  (key_c[i]),
			.hit_in   (hit_c[i+1]),
			.hit_out  (hit_c[i]),
			.tap_in   (tap_c[i]),
			.tap_out  (tap_c[i+1])
		);
	end

endmodule
`default_nettype wire

// ===== bench/tb_lru_domain_tag_cache.sv =====
// Self-checking testbench for the domain id / time step LRU tag cache.
module tb_lru_domain_tag_cache;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ENTRIES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		ltc_pkg::status_t status;
		logic             present;
		logic             ev_valid;
		logic [31:0]      ev_domain;
		logic [31:0]      ev_time;
		logic [31:0]      loads;
		logic [31:0]      purges;
	} lookup_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic               cfg_index = 1'b0;
	logic [6:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = '0;
	logic signed [31:0] domain_id = '0;
	logic signed [31:0] time_step = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic               present;
	logic               evicted_valid;
	logic signed [31:0] evicted_domain;
	logic signed [31:0] evicted_time;
	logic [31:0]        loads_total;
	logic [31:0]        purges_total;

	// shadow copy of the cache state
	ltc_pkg::key_t model_tags [MAX_ENTRIES];
	int            model_occupancy = 0;
	logic [31:0]   model_loads = '0;
	logic [31:0]   model_purges = '0;
	int            model_capacity = int'(ltc_pkg::CAPACITY_RST);
	logic          model_on_demand = 1'b0;

	lookup_result_t pending_results [$];
	int             error_count = 0;
	int             cycle_count = 0;
	int             hold_cycles = 0;
	bit             steady_sender = 1'b0;
	bit             steady_receiver = 1'b0;

	lru_domain_tag_cache #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.domain_id(domain_id),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.present(present),
		.evicted_valid(evicted_valid),
		.evicted_domain(evicted_domain),
		.evicted_time(evicted_time),
		.loads_total(loads_total),
		.purges_total(purges_total)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lru_domain_tag_cache verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, optional long hold-off counted here.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else if (steady_receiver) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 23);
		end
	end

	task automatic report_mismatch(string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Move positions 0..count-1 one place towards the least recent end.
	function automatic void age_tags(int count);
		for (int i = count; i > 0; i--) begin
			if (i < MAX_ENTRIES)
				model_tags[i] = model_tags[i-1];
		end
	endfunction

	function automatic lookup_result_t predict_lookup(logic [1:0] op, logic [31:0] dom,
			logic [31:0] ts);
		lookup_result_t r;
		ltc_pkg::key_t key;
		ltc_pkg::key_t victim;
		int occ;
		int cap_eff;
		int hit;
		r = '0;
		key = {ts, dom};
		victim = '0;
		occ = (model_occupancy > MAX_ENTRIES) ? MAX_ENTRIES : model_occupancy;
		cap_eff = (model_capacity > MAX_ENTRIES) ? MAX_ENTRIES : model_capacity;
		hit = -1;
		if (op == ltc_pkg::OP_CLEAR) begin
			model_occupancy = 0;
		end else if (op == ltc_pkg::OP_FETCH || op == ltc_pkg::OP_QUERY) begin
			if (!model_on_demand) begin
				r.status = ltc_pkg::ST_OFF;
			end else if (dom[31]) begin
				r.status = ltc_pkg::ST_NEG;
			end else begin
				for (int i = 0; i < occ; i++) begin
					if (hit < 0 && model_tags[i] == key)
						hit = i;
				end
				if (op == ltc_pkg::OP_QUERY) begin
					r.present = (hit >= 0);
				end else if (hit >= 0) begin
					age_tags(hit);
					model_tags[0] = key;
				end else begin
					r.status = ltc_pkg::ST_MISS;
					model_loads++;
					if (occ + 1 > cap_eff) begin
						r.ev_valid = 1'b1;
						model_purges++;
						// an empty store with no room hands the new key straight back
						if (occ == 0) begin
							victim = key;
						end else begin
							victim = model_tags[occ-1];
							age_tags(occ - 1);
							model_tags[0] = key;
						end
					end else begin
						age_tags(occ);
						model_tags[0] = key;
						occ++;
					end
					model_occupancy = occ;
				end
			end
		end
		r.ev_domain = victim[31:0];
		r.ev_time = victim[63:32];
		r.loads = model_loads;
		r.purges = model_purges;
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with no request outstanding");
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("status", 32'(status), 32'(want.status));
				check_field("present", 32'(present), 32'(want.present));
				check_field("evicted_valid", 32'(evicted_valid), 32'(want.ev_valid));
				check_field("evicted_domain", evicted_domain, want.ev_domain);
				check_field("evicted_time", evicted_time, want.ev_time);
				check_field("loads_total", loads_total, want.loads);
				check_field("purges_total", purges_total, want.purges);
			end
		end
	end

	task automatic send_request(logic [1:0] op, logic [31:0] dom, logic [31:0] ts);
		@(negedge clk);
		if (!steady_sender && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		domain_id <= dom;
		time_step <= ts;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(), predict_lookup(op, dom, ts));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic idx, int value);
		wait_idle();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[6:0];
		@(posedge clk);
		if (idx == ltc_pkg::CFG_CAPACITY)
			model_capacity = value & 8'h7F;
		else
			model_on_demand = value[0];
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Out of reset the mode is off: lookups error, clear and spare still answer.
	task automatic test_reset_defaults();
		send_request(ltc_pkg::OP_FETCH, 32'd1, 32'd1);
		send_request(ltc_pkg::OP_QUERY, 32'd1, 32'd1);
		send_request(ltc_pkg::OP_FETCH, 32'hFFFF_FFFF, 32'h8000_0000);
		send_request(ltc_pkg::OP_CLEAR, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_SPARE, 32'h1234_5678, 32'h9ABC_DEF0);
	endtask

	task automatic test_directed_cases();
		write_register(ltc_pkg::CFG_ON_DEMAND, 1);
		send_request(ltc_pkg::OP_FETCH, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_FETCH, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(ltc_pkg::OP_FETCH, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_FETCH, 32'd5, 32'h8000_0000);
		send_request(ltc_pkg::OP_QUERY, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(ltc_pkg::OP_FETCH, 32'h8000_0000, 32'd3);
		send_request(ltc_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ltc_pkg::OP_SPARE, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_CLEAR, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_QUERY, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_FETCH, 32'd1, 32'hFFFF_FFFF);
		// no room at all: every miss evicts
		write_register(ltc_pkg::CFG_CAPACITY, 0);
		send_request(ltc_pkg::OP_FETCH, 32'd2, 32'd3);
		send_request(ltc_pkg::OP_CLEAR, 32'd0, 32'd0);
		send_request(ltc_pkg::OP_FETCH, 32'd4, 32'd4);
		// fill, then shrink below occupancy: one eviction per miss until capacity is raised
		write_register(ltc_pkg::CFG_CAPACITY, 8);
		for (int i = 0; i < 6; i++)
			send_request(ltc_pkg::OP_FETCH, 32'd10 + i, 32'd7);
		write_register(ltc_pkg::CFG_CAPACITY, 2);
		send_request(ltc_pkg::OP_FETCH, 32'd20, 32'd7);
		send_request(ltc_pkg::OP_FETCH, 32'd21, 32'd7);
		write_register(ltc_pkg::CFG_CAPACITY, 127);
		send_request(ltc_pkg::OP_FETCH, 32'd22, 32'd7);
		send_request(ltc_pkg::OP_QUERY, 32'd12, 32'd7);
		write_register(ltc_pkg::CFG_ON_DEMAND, 0);
		send_request(ltc_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0);
	endtask

	task automatic test_random_traffic(int cap, bit mode, int count);
		logic [31:0] pool_dom [16];
		logic [31:0] pool_ts [16];
		logic [31:0] dom;
		logic [31:0] ts;
		int pool_size;
		int pick;
		int roll;
		pool_size = ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap) + 3;
		for (int i = 0; i < pool_size; i++) begin
			pool_dom[i] = $urandom_range(1) ? $urandom_range(0, 15) : ($urandom & 32'h7FFF_FFFF);
			pool_ts[i] = $urandom_range(1) ? $urandom_range(0, 3) : $urandom;
		end
		write_register(ltc_pkg::CFG_CAPACITY, cap);
		write_register(ltc_pkg::CFG_ON_DEMAND, mode);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			pick = $urandom_range(pool_size - 1);
			if (roll < 3) begin
				send_request(ltc_pkg::OP_CLEAR, $urandom, $urandom);
			end else if (roll < 5) begin
				send_request(ltc_pkg::OP_SPARE, $urandom, $urandom);
			end else if (roll < 10) begin
				dom = $urandom | 32'h8000_0000;
				send_request($urandom_range(1) ? ltc_pkg::OP_FETCH : ltc_pkg::OP_QUERY,
					dom, $urandom);
			end else if (roll < 14) begin
				ts = $urandom;
				send_request(ltc_pkg::OP_FETCH, $urandom & 32'h7FFF_FFFF, ts);
			end else if (roll < 78) begin
				send_request(ltc_pkg::OP_FETCH, pool_dom[pick], pool_ts[pick]);
			end else begin
				send_request(ltc_pkg::OP_QUERY, pool_dom[pick], pool_ts[pick]);
			end
		end
	endtask

	// Hold results back while requests keep coming so the input stalls.
	task automatic test_output_backpressure();
		write_register(ltc_pkg::CFG_CAPACITY, 4);
		write_register(ltc_pkg::CFG_ON_DEMAND, 1);
		steady_sender = 1'b1;
		@(posedge clk);
		hold_cycles = 60;
		for (int i = 0; i < 40; i++)
			send_request(ltc_pkg::OP_FETCH, i % 6, i % 3);
		steady_sender = 1'b0;
	endtask

	task automatic test_back_to_back();
		steady_sender = 1'b1;
		steady_receiver = 1'b1;
		test_random_traffic(6, 1'b1, 150);
		wait_idle();
		steady_sender = 1'b0;
		steady_receiver = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_cases();
		test_random_traffic(1, 1'b1, 180);
		test_random_traffic(8, 1'b1, 180);
		test_random_traffic(3, 1'b1, 180);
		test_random_traffic(64, 1'b1, 180);
		test_random_traffic(0, 1'b1, 120);
		test_random_traffic(127, 1'b1, 180);
		test_random_traffic(5, 1'b0, 60);
		test_random_traffic($urandom_range(2, 7), 1'b1, 180);
		test_output_backpressure();
		test_back_to_back();
		wait_idle();
		if (pending_results.size() != 0)
			report_mismatch("results still outstanding at end of run");
		if (error_count == 0)
			$display("lru_domain_tag_cache verification clean");
		else
			$display("lru_domain_tag_cache verification failed");
		$finish;
	end

endmodule
